// File: design/cem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cem_pkg;

  localparam int GROUP_W     = 12;
  localparam int GROUP_SLOTS = 4096;
  localparam int FRAC_W      = 16;
  localparam int Q_W         = 17;
  localparam int RSUM_W      = GROUP_W + Q_W;
  localparam int PRES_W      = 13;
  localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

  typedef logic [23:0] cnt_out_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_EDGE   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] node_a;
    logic [11:0] node_b;
    logic [11:0] community;
  } item_t;

  typedef struct packed {
    logic [16:0] coverage;
    logic [16:0] conductivity;
    logic [12:0] community_total;
    logic [23:0] edge_total;
    logic [23:0] internal_total;
  } result_t;

  // classified item as held in the queue
  typedef struct packed {
    op_e         op;
    logic [11:0] a;
    logic [11:0] b;
    logic [11:0] comm;
    logic        a_ok;
    logic        b_ok;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LD,
    ST_LD_WR,
    ST_ED_RD,
    ST_ED_GRP,
    ST_ED_WR1,
    ST_ED_WR2,
    ST_FN_RD,
    ST_FN_DAT,
    ST_FN_DIV,
    ST_FN_COV,
    ST_FN_COVW,
    ST_FN_CND,
    ST_FN_CNDW,
    ST_FN_OUT
  } state_e;

endpackage
`default_nettype wire

// File: design/cem_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cem_front #(
  parameter int NODE_SLOTS = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  cem_pkg::item_t  item_i,
  input  logic            init_busy_i,
  input  logic            pop_i,
  output logic            busy_o,
  output cem_pkg::head_t  head_o
);

  localparam int QDEPTH = 2;

  cem_pkg::cmd_t slot_q [QDEPTH];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  cem_pkg::cmd_t cmd;
  logic          push;

  always_comb begin
    cmd.op   = cem_pkg::op_e'(item_i.action);
    cmd.a    = item_i.node_a;
    cmd.b    = item_i.node_b;
    cmd.comm = item_i.community;
    cmd.a_ok = 32'(item_i.node_a) < NODE_SLOTS;
    cmd.b_ok = 32'(item_i.node_b) < NODE_SLOTS;
  end

  assign busy_o = (cnt_q == 2'(QDEPTH)) | init_busy_i;
  // idle actions are dropped here
  assign push   = start_i & ~busy_o & (cmd.op != cem_pkg::OP_NONE);

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = slot_q[rd_q];

endmodule
`default_nettype wire

// File: design/cem_div.sv
`timescale 1ns / 1ps
`default_nettype none
module cem_div #(
  parameter int NUMW = 41,
  parameter int DENW = 26
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NUMW-1:0]          num_i,
  input  logic [DENW-1:0]          den_i,
  output logic                     done_o,
  output logic [cem_pkg::Q_W-1:0]  quot_o
);

  // quotient is known to fit Q_W bits; one bit per cycle, MSB first
  localparam int CMPW = (NUMW > DENW + cem_pkg::Q_W - 1) ? NUMW : DENW + cem_pkg::Q_W - 1;
  localparam int STW  = $clog2(cem_pkg::Q_W);

  logic [CMPW-1:0]         rem_q, dsh_q;
  logic [cem_pkg::Q_W-1:0] quot_q;
  logic [STW-1:0]          step_q;
  logic                    run_q, done_q;
  logic                    ge;

  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= CMPW'(num_i);
      dsh_q  <= CMPW'({den_i, {(cem_pkg::Q_W-1){1'b0}}});
      quot_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[cem_pkg::Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= run_q && (step_q == '0);
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= STW'(cem_pkg::Q_W - 1);
      end else if (run_q) begin
        if (step_q == '0) begin
          run_q <= 1'b0;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// File: design/cem_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cem_back #(
  parameter int NODE_SLOTS  = 4096,
  parameter int COUNT_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cem_pkg::head_t    head_i,
  output logic              pop_o,
  output logic              init_busy_o,
  output logic              done_o,
  output cem_pkg::result_t  result_o
);

  localparam int CW      = COUNT_WIDTH;
  localparam int GW      = cem_pkg::GROUP_W;
  localparam int NA      = $clog2(NODE_SLOTS);
  localparam int NWORD   = GW + 1;
  localparam int GWORD   = 2 * CW + 1;
  localparam int SWEEP_N = (NODE_SLOTS > cem_pkg::GROUP_SLOTS) ? NODE_SLOTS
                                                                : cem_pkg::GROUP_SLOTS;
  localparam int SW      = $clog2(SWEEP_N);
  localparam int NUMW    = (CW + cem_pkg::Q_W > cem_pkg::RSUM_W) ? CW + cem_pkg::Q_W
                                                                  : cem_pkg::RSUM_W;
  localparam int DENW    = (CW + 2 > cem_pkg::PRES_W) ? CW + 2 : cem_pkg::PRES_W;

  // memories: node word {known, group}, group word {present, internal, boundary}
  logic [NWORD-1:0] nmem [NODE_SLOTS];
  logic [GWORD-1:0] gmem [cem_pkg::GROUP_SLOTS];

  logic             n_we, n_re;
  logic [NA-1:0]    n_wa, n_raa, n_rab;
  logic [NWORD-1:0] n_wd, n_rda_q, n_rdb_q;
  logic             g_we, g_re;
  logic [GW-1:0]    g_wa, g_raa, g_rab;
  logic [GWORD-1:0] g_wd, g_rda_q, g_rdb_q;

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      nmem[n_wa] <= n_wd;
    end
    if (n_re) begin
      n_rda_q <= nmem[n_raa];
      n_rdb_q <= nmem[n_rab];
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem[g_wa] <= g_wd;
    end
    if (g_re) begin
      g_rda_q <= gmem[g_raa];
      g_rdb_q <= gmem[g_rab];
    end
  end

  cem_pkg::state_e          state_q, state_d;
  cem_pkg::cmd_t            cmd_q;
  logic [SW-1:0]            ctr_q;
  logic [CW-1:0]            edges_q, isum_q;
  logic [cem_pkg::RSUM_W-1:0] rsum_q;
  logic [cem_pkg::PRES_W-1:0] pres_q;
  logic [cem_pkg::Q_W-1:0]  cov_q, cond_q;
  cem_pkg::result_t         res_q;
  logic                     done_q;

  logic cmd_ld, ctr_clr, ctr_inc, fin_clr, edge_inc, grp_acc, rsum_add;
  logic cov_ld, cond_ld, out_ld;
  logic [cem_pkg::Q_W-1:0] q_val;

  logic                  div_start, div_done;
  logic [NUMW-1:0]       div_num;
  logic [DENW-1:0]       div_den;
  logic [cem_pkg::Q_W-1:0] div_quot, quot_cl;

  logic          ka, kb, same, node_ok, grp_ok, last;
  logic [GW-1:0] ga, gb;
  logic [CW-1:0] int_a, bnd_a, bnd_b, int_a_inc, bnd_a_inc, bnd_b_inc;
  logic          pres_a, pres_b;
  logic [DENW-1:0] den_r;
  logic [CW:0]   isum_sum;

  assign ka    = cmd_q.a_ok & n_rda_q[GW];
  assign kb    = cmd_q.b_ok & n_rdb_q[GW];
  assign ga    = n_rda_q[GW-1:0];
  assign gb    = n_rdb_q[GW-1:0];
  assign same  = ka & kb & (ga == gb);

  assign pres_a = g_rda_q[GWORD-1];
  assign int_a  = g_rda_q[2*CW-1:CW];
  assign bnd_a  = g_rda_q[CW-1:0];
  assign pres_b = g_rdb_q[GWORD-1];
  assign bnd_b  = g_rdb_q[CW-1:0];

  assign int_a_inc = (&int_a) ? int_a : int_a + 1'b1;
  assign bnd_a_inc = (&bnd_a) ? bnd_a : bnd_a + 1'b1;
  assign bnd_b_inc = (&bnd_b) ? bnd_b : bnd_b + 1'b1;

  assign den_r    = DENW'(bnd_a) + DENW'({int_a, 1'b0});
  assign isum_sum = {1'b0, isum_q} + {1'b0, int_a};
  assign quot_cl  = (div_quot > cem_pkg::Q_ONE) ? cem_pkg::Q_ONE : div_quot;

  assign node_ok = 32'(ctr_q) < NODE_SLOTS;
  assign grp_ok  = 32'(ctr_q) < cem_pkg::GROUP_SLOTS;
  assign last    = (ctr_q == SW'(SWEEP_N - 1));

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    cmd_ld    = 1'b0;
    ctr_clr   = 1'b0;
    ctr_inc   = 1'b0;
    fin_clr   = 1'b0;
    edge_inc  = 1'b0;
    grp_acc   = 1'b0;
    rsum_add  = 1'b0;
    cov_ld    = 1'b0;
    cond_ld   = 1'b0;
    out_ld    = 1'b0;
    q_val     = '0;
    n_we      = 1'b0;
    n_wa      = ctr_q[NA-1:0];
    n_wd      = '0;
    n_re      = 1'b0;
    n_raa     = NA'(cmd_q.a);
    n_rab     = NA'(cmd_q.b);
    g_we      = 1'b0;
    g_wa      = ctr_q[GW-1:0];
    g_wd      = '0;
    g_re      = 1'b0;
    g_raa     = ctr_q[GW-1:0];
    g_rab     = gb;
    div_start = 1'b0;
    div_num   = NUMW'({bnd_a, {cem_pkg::FRAC_W{1'b0}}}) + NUMW'(den_r >> 1);
    div_den   = den_r;
    case (state_q)
      cem_pkg::ST_INIT: begin
        n_we = node_ok;
        g_we = grp_ok;
        if (last) begin
          state_d = cem_pkg::ST_IDLE;
        end else begin
          ctr_inc = 1'b1;
        end
      end
      cem_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o  = 1'b1;
          cmd_ld = 1'b1;
          case (head_i.cmd.op)
            cem_pkg::OP_LOAD:   state_d = cem_pkg::ST_LD;
            cem_pkg::OP_EDGE:   state_d = cem_pkg::ST_ED_RD;
            cem_pkg::OP_FINISH: begin
              fin_clr = 1'b1;
              ctr_clr = 1'b1;
              state_d = cem_pkg::ST_FN_RD;
            end
            default:            state_d = cem_pkg::ST_IDLE;
          endcase
        end
      end
      cem_pkg::ST_LD: begin
        if (cmd_q.a_ok) begin
          n_we    = 1'b1;
          n_wa    = NA'(cmd_q.a);
          n_wd    = {1'b1, cmd_q.comm};
          g_re    = 1'b1;
          g_raa   = cmd_q.comm;
          state_d = cem_pkg::ST_LD_WR;
        end else begin
          state_d = cem_pkg::ST_IDLE;
        end
      end
      cem_pkg::ST_LD_WR: begin
        if (!pres_a) begin
          g_we = 1'b1;
          g_wa = cmd_q.comm;
          g_wd = {1'b1, g_rda_q[2*CW-1:0]};
        end
        state_d = cem_pkg::ST_IDLE;
      end
      cem_pkg::ST_ED_RD: begin
        n_re    = 1'b1;
        state_d = cem_pkg::ST_ED_GRP;
      end
      cem_pkg::ST_ED_GRP: begin
        g_re    = 1'b1;
        g_raa   = ga;
        g_rab   = gb;
        state_d = cem_pkg::ST_ED_WR1;
      end
      cem_pkg::ST_ED_WR1: begin
        edge_inc = 1'b1;
        g_wa     = ga;
        if (same) begin
          g_we = 1'b1;
          g_wd = {pres_a, int_a_inc, bnd_a};
        end else if (ka) begin
          g_we = 1'b1;
          g_wd = {pres_a, int_a, bnd_a_inc};
        end
        state_d = (!same && kb) ? cem_pkg::ST_ED_WR2 : cem_pkg::ST_IDLE;
      end
      cem_pkg::ST_ED_WR2: begin
        g_we    = 1'b1;
        g_wa    = gb;
        g_wd    = {pres_b, g_rdb_q[2*CW-1:CW], bnd_b_inc};
        state_d = cem_pkg::ST_IDLE;
      end
      cem_pkg::ST_FN_RD: begin
        n_we = node_ok;
        if (grp_ok) begin
          g_re    = 1'b1;
          g_we    = 1'b1;
          state_d = cem_pkg::ST_FN_DAT;
        end else if (last) begin
          state_d = cem_pkg::ST_FN_COV;
        end else begin
          ctr_inc = 1'b1;
        end
      end
      cem_pkg::ST_FN_DAT: begin
        if (pres_a && den_r != '0) begin
          grp_acc   = 1'b1;
          div_start = 1'b1;
          state_d   = cem_pkg::ST_FN_DIV;
        end else begin
          grp_acc = pres_a;
          if (last) begin
            state_d = cem_pkg::ST_FN_COV;
          end else begin
            ctr_inc = 1'b1;
            state_d = cem_pkg::ST_FN_RD;
          end
        end
      end
      cem_pkg::ST_FN_DIV: begin
        if (div_done) begin
          rsum_add = 1'b1;
          if (last) begin
            state_d = cem_pkg::ST_FN_COV;
          end else begin
            ctr_inc = 1'b1;
            state_d = cem_pkg::ST_FN_RD;
          end
        end
      end
      cem_pkg::ST_FN_COV: begin
        div_num = NUMW'({isum_q, {cem_pkg::FRAC_W{1'b0}}}) + NUMW'(edges_q >> 1);
        div_den = DENW'(edges_q);
        if (edges_q != '0) begin
          div_start = 1'b1;
          state_d   = cem_pkg::ST_FN_COVW;
        end else begin
          cov_ld  = 1'b1;
          state_d = cem_pkg::ST_FN_CND;
        end
      end
      cem_pkg::ST_FN_COVW: begin
        if (div_done) begin
          cov_ld  = 1'b1;
          q_val   = quot_cl;
          state_d = cem_pkg::ST_FN_CND;
        end
      end
      cem_pkg::ST_FN_CND: begin
        div_num = NUMW'(rsum_q) + NUMW'(pres_q >> 1);
        div_den = DENW'(pres_q);
        if (pres_q != '0) begin
          div_start = 1'b1;
          state_d   = cem_pkg::ST_FN_CNDW;
        end else begin
          cond_ld = 1'b1;
          state_d = cem_pkg::ST_FN_OUT;
        end
      end
      cem_pkg::ST_FN_CNDW: begin
        if (div_done) begin
          cond_ld = 1'b1;
          q_val   = quot_cl;
          state_d = cem_pkg::ST_FN_OUT;
        end
      end
      cem_pkg::ST_FN_OUT: begin
        out_ld  = 1'b1;
        state_d = cem_pkg::ST_IDLE;
      end
      default: state_d = cem_pkg::ST_IDLE;
    endcase
  end

  cem_div #(
    .NUMW (NUMW),
    .DENW (DENW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cem_pkg::ST_INIT;
      ctr_q   <= '0;
      edges_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= out_ld;
      if (ctr_clr) begin
        ctr_q <= '0;
      end else if (ctr_inc) begin
        ctr_q <= ctr_q + 1'b1;
      end
      if (out_ld) begin
        edges_q <= '0;
      end else if (edge_inc && !(&edges_q)) begin
        edges_q <= edges_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ld) begin
      cmd_q <= head_i.cmd;
    end
    if (fin_clr) begin
      isum_q <= '0;
      rsum_q <= '0;
      pres_q <= '0;
    end else begin
      if (grp_acc) begin
        pres_q <= pres_q + 1'b1;
        isum_q <= isum_sum[CW] ? {CW{1'b1}} : isum_sum[CW-1:0];
      end
      if (rsum_add) begin
        rsum_q <= rsum_q + cem_pkg::RSUM_W'(div_quot);
      end
    end
    if (cov_ld) begin
      cov_q <= q_val;
    end
    if (cond_ld) begin
      cond_q <= q_val;
    end
    if (out_ld) begin
      res_q.coverage        <= cov_q;
      res_q.conductivity    <= cond_q;
      res_q.community_total <= pres_q;
      res_q.edge_total      <= cem_pkg::cnt_out_t'(edges_q);
      res_q.internal_total  <= cem_pkg::cnt_out_t'(isum_q);
    end
  end

  assign init_busy_o = (state_q == cem_pkg::ST_INIT);
  assign done_o      = done_q;
  assign result_o    = res_q;

endmodule
`default_nettype wire

// File: design/community_edge_metrics_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: node word written, then community marked present. Edge: node words read, then
//   community words, then up to two counts written. Finish: all slots walked and
//   cleared, dividing per present community. Back end: one item at a time, by
//   read-modify-write of node and community memories; a 2-item queue absorbs bursts.
// Reset: async, active low; then a clearing pass over max(NODE_SLOTS, 4096) slots
//   with busy high. Results strobe on done_o for one cycle; receiver cannot stall.
module community_edge_metrics_core #(
  parameter int NODE_SLOTS  = 4096,
  parameter int COUNT_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  cem_pkg::item_t    item_i,
  output logic              busy,
  output logic              done_o,
  output cem_pkg::result_t  result_o
);

  // front: classifies items (action, node range) and queues them
  cem_pkg::head_t head;
  logic           pop;
  logic           init_busy;

  cem_front #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item_i),
    .init_busy_i (init_busy),
    .pop_i       (pop),
    .busy_o      (busy),
    .head_o      (head)
  );

  // back: node/community memories, counter updates, finish walk and divider
  cem_back #(
    .NODE_SLOTS  (NODE_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

// File: design/cem_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module cem_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             done_i,
  input cem_pkg::result_t result_i
);

  // a finish walk is long, so results never come back to back
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i) else $error("done strobe longer than one cycle");

  a_cov_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> result_i.coverage <= cem_pkg::Q_ONE) else $error("coverage above one");

  a_cond_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> result_i.conductivity <= cem_pkg::Q_ONE) else $error("conductivity above one");

  a_cond_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && result_i.community_total == '0 |-> result_i.conductivity == '0)
    else $error("conductivity nonzero without communities");

endmodule

bind community_edge_metrics_core cem_checker u_cem_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .done_i   (done_o),
  .result_i (result_o)
);
`default_nettype wire

// File: dv/tb_community_edge_metrics_core.sv
`timescale 1ns / 1ps
module tb_community_edge_metrics_core;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 100;
  localparam longint CNT_MAX    = (64'd1 << 24) - 1;

  // an item waiting to be driven, with the sender idle rate of its phase
  typedef struct {
    cem_pkg::item_t item;
    int             idle_pct;
  } pending_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start = 1'b0;
  cem_pkg::item_t   item_i = '0;
  logic             busy;
  logic             done_o;
  cem_pkg::result_t result_o;

  pending_t         pending_items[$];
  cem_pkg::result_t metrics_due[$];
  int               mismatch_cnt = 0;
  int               stall_cycles = 0;
  bit               took_item = 1'b0;

  // shadow copy of the partition scores
  logic [11:0] shadow_group[4096];
  bit          shadow_known[4096];
  bit          shadow_present[4096];
  longint      shadow_internal[4096];
  longint      shadow_boundary[4096];
  longint      shadow_edges = 0;

  community_edge_metrics_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint round_div(longint num, longint den);
    if (den == 0) return 0;
    return (num + den / 2) / den;
  endfunction

  function automatic longint bump(longint v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 1;
  endfunction

  function automatic void clear_scores();
    for (int g = 0; g < 4096; g++) begin
      shadow_known[g]    = 1'b0;
      shadow_present[g]  = 1'b0;
      shadow_internal[g] = 0;
      shadow_boundary[g] = 0;
    end
    shadow_edges = 0;
  endfunction

  // update the shadow scores; a finish queues the metrics it should emit
  function automatic void score_partition(cem_pkg::item_t it);
    cem_pkg::result_t r;
    longint  isum, rsum, npres, cov, cond;
    logic [11:0] ga, gb;
    bit ka, kb;
    case (cem_pkg::op_e'(it.action))
      cem_pkg::OP_LOAD: begin
        shadow_group[it.node_a] = it.community;
        shadow_known[it.node_a] = 1'b1;
        shadow_present[it.community] = 1'b1;
      end
      cem_pkg::OP_EDGE: begin
        ka = shadow_known[it.node_a];
        kb = shadow_known[it.node_b];
        ga = shadow_group[it.node_a];
        gb = shadow_group[it.node_b];
        if (ka && kb && ga == gb) begin
          shadow_internal[ga] = bump(shadow_internal[ga]);
        end else begin
          if (ka) shadow_boundary[ga] = bump(shadow_boundary[ga]);
          if (kb) shadow_boundary[gb] = bump(shadow_boundary[gb]);
        end
        shadow_edges = bump(shadow_edges);
      end
      cem_pkg::OP_FINISH: begin
        isum = 0; rsum = 0; npres = 0;
        for (int g = 0; g < 4096; g++) begin
          if (shadow_present[g]) begin
            npres++;
            isum += shadow_internal[g];
            if (isum > CNT_MAX) isum = CNT_MAX;
            rsum += round_div(shadow_boundary[g] * 65536,
                              shadow_boundary[g] + 2 * shadow_internal[g]);
          end
        end
        cov  = round_div(isum * 65536, shadow_edges);
        cond = round_div(rsum, npres);
        if (cov > 65536) cov = 65536;
        if (cond > 65536) cond = 65536;
        r.coverage        = cov[16:0];
        r.conductivity    = cond[16:0];
        r.community_total = npres[12:0];
        r.edge_total      = shadow_edges[23:0];
        r.internal_total  = isum[23:0];
        metrics_due = {metrics_due, r};
        clear_scores();
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(cem_pkg::op_e op, int a, int b, int comm, int idle);
    pending_t p;
    p.item.action    = op;
    p.item.node_a    = a[11:0];
    p.item.node_b    = b[11:0];
    p.item.community = comm[11:0];
    p.idle_pct       = idle;
    pending_items = {pending_items, p};
  endfunction

  // driver: inputs move on the falling edge, one assignment per signal
  always @(negedge clk_i) begin
    logic           nxt_start;
    cem_pkg::item_t nxt_item;
    pending_t       nxt_p;
    nxt_start = start;
    nxt_item  = item_i;
    if (rst_ni && (!start || took_item)) begin
      took_item = 1'b0;
      nxt_start = 1'b0;
      if (pending_items.size() > 0 &&
          $urandom_range(99) >= pending_items[0].idle_pct) begin
        nxt_p     = pending_items.pop_front();
        nxt_item  = nxt_p.item;
        nxt_start = 1'b1;
      end
    end
    start  <= nxt_start;
    item_i <= nxt_item;
  end

  // monitor: check results, predict on acceptance, watch for a hang
  always @(posedge clk_i) begin
    cem_pkg::result_t exp;
    if (rst_ni) begin
      if (done_o) begin
        if (metrics_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result %p", result_o);
        end else begin
          exp = metrics_due.pop_front();
          if (result_o.coverage !== exp.coverage ||
              result_o.conductivity !== exp.conductivity ||
              result_o.community_total !== exp.community_total ||
              result_o.edge_total !== exp.edge_total ||
              result_o.internal_total !== exp.internal_total) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("metrics mismatch: exp %p got %p", exp, result_o);
          end
        end
      end
      if (start && !busy) begin
        score_partition(item_i);
        took_item = 1'b1;
      end
      // the clearing pass after reset and long finish walks fit in the limit
      if ((start && !busy) || done_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int comms[$];
    int nodes[$];
    int idle, ncomm, nnode, nitems, pick;
    rst_ni = 1'b0;
    clear_scores();
    // directed: extremes, cross and internal edges, untagged ends, reloads
    queue_item(cem_pkg::OP_FINISH, 0, 0, 0, 0);                // nothing seen at all
    queue_item(cem_pkg::OP_EDGE, 5, 6, 0, 0);                  // edge before any load
    queue_item(cem_pkg::OP_LOAD, 0, 0, 0, 0);
    queue_item(cem_pkg::OP_LOAD, 4095, 0, 4095, 0);
    queue_item(cem_pkg::OP_LOAD, 1, 0, 0, 0);
    queue_item(cem_pkg::OP_EDGE, 0, 1, 0, 0);                  // internal
    queue_item(cem_pkg::OP_EDGE, 0, 4095, 0, 0);               // across
    queue_item(cem_pkg::OP_EDGE, 4095, 77, 0, 0);              // one end untagged
    queue_item(cem_pkg::OP_EDGE, 77, 78, 4095, 0);             // no end tagged
    queue_item(cem_pkg::OP_EDGE, 4095, 4095, 0, 0);            // self loop
    queue_item(cem_pkg::OP_NONE, 4095, 4095, 4095, 0);         // ignored
    queue_item(cem_pkg::OP_LOAD, 1, 0, 4095, 0);               // reload to new group
    queue_item(cem_pkg::OP_EDGE, 1, 4095, 0, 0);
    queue_item(cem_pkg::OP_EDGE, 1, 0, 0, 0);
    queue_item(cem_pkg::OP_FINISH, 4095, 4095, 4095, 0);
    queue_item(cem_pkg::OP_LOAD, 2730, 0, 1365, 0);            // groups but no edges
    queue_item(cem_pkg::OP_LOAD, 1365, 0, 2730, 0);
    queue_item(cem_pkg::OP_FINISH, 0, 0, 0, 0);
    queue_item(cem_pkg::OP_EDGE, 2730, 1365, 0, 0);            // tags cleared by finish
    queue_item(cem_pkg::OP_FINISH, 0, 0, 0, 0);

    // random: well-formed partitions with noise, one finish per set
    for (int s = 0; pending_items.size() < 1520; s++) begin
      case (s % 3)
        0: idle = 0;
        1: idle = 78;
        default: idle = 24;
      endcase
      comms.delete();
      nodes.delete();
      ncomm = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(8, 1);
      nnode = $urandom_range(24, 2);
      nitems = $urandom_range(45, 10);
      for (int i = 0; i < ncomm; i++) comms = {comms, int'($urandom_range(4095))};
      for (int i = 0; i < nnode; i++) nodes = {nodes, int'($urandom_range(4095))};
      for (int i = 0; i < nnode; i++)
        if ($urandom_range(4) != 0)
          queue_item(cem_pkg::OP_LOAD, nodes[i], $urandom_range(4095),
                     comms[$urandom_range(ncomm - 1)], idle);
      for (int i = 0; i < nitems; i++) begin
        pick = $urandom_range(99);
        if (pick < 65)
          queue_item(cem_pkg::OP_EDGE, nodes[$urandom_range(nnode - 1)],
                     nodes[$urandom_range(nnode - 1)], $urandom_range(4095), idle);
        else if (pick < 80)
          queue_item(cem_pkg::OP_LOAD, nodes[$urandom_range(nnode - 1)],
                     $urandom_range(4095), comms[$urandom_range(ncomm - 1)], idle);
        else if (pick < 90)
          queue_item(cem_pkg::OP_EDGE, $urandom_range(4095),
                     nodes[$urandom_range(nnode - 1)], $urandom_range(4095), idle);
        else
          queue_item(cem_pkg::OP_NONE, $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), idle);
      end
      queue_item(cem_pkg::OP_FINISH, $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(4095), idle);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_items.size() == 0 && !start);
    wait (metrics_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && metrics_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
design/cem_pkg.sv
design/cem_front.sv
design/cem_div.sv
design/cem_back.sv
design/community_edge_metrics_core.sv
design/cem_checker.sv
dv/tb_community_edge_metrics_core.sv
